// ----- rtl/gcsp_pkg.sv -----
// ----------------------------------------------------------------------------
// gcsp_pkg
// Shared codes and types for the GPU command stream parser: result kinds,
// command opcodes, field widths and the result record.
// ----------------------------------------------------------------------------
package gcsp_pkg;

    localparam int WORD_W  = 32;
    localparam int INDEX_W = 16;
    localparam int REG_W   = 17;
    localparam int COUNT_W = 10;
    localparam int WORDS_W = 11;
    localparam int SLOT_W  = 3;
    localparam int KIND_W  = 2;
    localparam int OP_W    = 5;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

    // Command opcodes (header bits 31:27).
    localparam logic [OP_W-1:0] OP_NOP0       = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD_STATE = 5'd1;
    localparam logic [OP_W-1:0] OP_FILL_STATE = 5'd2;
    localparam logic [OP_W-1:0] OP_NOP3       = 5'd3;
    localparam logic [OP_W-1:0] OP_DRAW_IDX   = 5'd5;
    localparam logic [OP_W-1:0] OP_DRAW_6     = 5'd6;
    localparam logic [OP_W-1:0] OP_NOP9       = 5'd9;

    // Last slot of the two draw record lengths.
    localparam logic [SLOT_W-1:0] DRAW_LAST_SHORT = 3'd3;
    localparam logic [SLOT_W-1:0] DRAW_LAST_LONG  = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REG_W-1:0]  reg_index;
        logic [WORD_W-1:0] value;
        logic              clear_vertex_first;
        logic [SLOT_W-1:0] draw_slot;
        logic              draw_end;
        logic              last_of_item;
    } result_t;

    localparam result_t RESULT_NONE = '0;

endpackage

// ----- rtl/gpu_command_stream_parser.sv -----
// ----------------------------------------------------------------------------
// gpu_command_stream_parser
// Decodes a GPU command stream one word per item into state writes, fill
// requests, draw words and errors, through a two-entry result queue.
// ----------------------------------------------------------------------------
// A result is written into the result queue when its item is accepted.
// Throughput: one item per cycle while the output is taken every cycle; an
// item that causes two results (the end of an indexed draw, or the header
// second word of a draw) holds the input while the second result drains
// from the two-entry result queue.
// Reset clears the parse state, the queue and the registers to their defaults.
module gpu_command_stream_parser
    import gcsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // command word input
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [WORD_W-1:0]  cmd_word,
    // result output
    output logic               out_valid,
    input  logic               out_stall,
    output logic [KIND_W-1:0]  kind,
    output logic [REG_W-1:0]   reg_index,
    output logic [WORD_W-1:0]  value,
    output logic               clear_vertex_first,
    output logic [SLOT_W-1:0]  draw_slot,
    output logic               draw_end,
    output logic               last_of_item,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_LOAD = 3'd2;
    localparam logic [2:0] PH_PAD  = 3'd3;
    localparam logic [2:0] PH_DRAW = 3'd4;
    localparam logic [2:0] PH_HALT = 3'd5;

    localparam logic REG_VERTEX_BLOCK  = 1'b0;
    localparam logic REG_INDEX_CONTROL = 1'b1;

    localparam logic [INDEX_W-1:0] VERTEX_BLOCK_RESET = 16'd384;

    // Configuration registers.
    logic [INDEX_W-1:0] vertex_block_index_reg;
    logic [INDEX_W-1:0] index_control_index_reg;

    // Parse state.
    logic [2:0]         phase_reg,       phase_next;
    logic [WORD_W-1:0]  header_word_reg, header_word_next;
    logic [REG_W-1:0]   next_index_reg,  next_index_next;
    logic [WORDS_W-1:0] words_left_reg,  words_left_next;
    logic               pad_pending_reg, pad_pending_next;
    logic               draw_kind_reg,   draw_kind_next;
    logic [SLOT_W-1:0]  draw_pos_reg,    draw_pos_next;

    // Result queue.
    result_t            queue_reg [2];
    logic               rd_ptr_reg;
    logic               wr_ptr_reg;
    logic [1:0]         count_reg;

    result_t            res0;
    result_t            res1;
    logic [1:0]         n_res;
    logic               in_accept;
    logic               out_pop;
    logic [1:0]         push_n;

    logic               cfg_write;
    logic [OP_W-1:0]    opcode;
    logic [COUNT_W-1:0] count_field;
    logic [INDEX_W-1:0] addr_field;
    logic [WORDS_W-1:0] load_left;
    logic [WORDS_W-1:0] words_dec;
    logic [SLOT_W-1:0]  draw_last;
    logic               draw_done;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_VERTEX_BLOCK:  prdata = {16'd0, vertex_block_index_reg};
            REG_INDEX_CONTROL: prdata = {16'd0, index_control_index_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_block_index_reg  <= VERTEX_BLOCK_RESET;
            index_control_index_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_VERTEX_BLOCK:  vertex_block_index_reg  <= pwdata[INDEX_W-1:0];
                REG_INDEX_CONTROL: index_control_index_reg <= pwdata[INDEX_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshakes. The queue must have room for two results after this cycle's pop.
    assign out_valid = (count_reg != 2'd0);
    assign out_pop   = out_valid & ~out_stall;
    assign in_stall  = ~((count_reg == 2'd0) | ((count_reg == 2'd1) & out_pop));
    assign in_accept = in_valid & ~in_stall;

    assign opcode      = header_word_reg[31:27];
    assign count_field = header_word_reg[25:16];
    assign addr_field  = header_word_reg[15:0];
    assign load_left   = {1'b0, count_field} - 11'd1;
    assign words_dec   = words_left_reg - 11'd1;
    assign draw_last   = draw_kind_reg ? DRAW_LAST_LONG : DRAW_LAST_SHORT;
    assign draw_done   = (draw_pos_reg >= draw_last);

    always_comb
    begin
        phase_next       = phase_reg;
        header_word_next = header_word_reg;
        next_index_next  = next_index_reg;
        words_left_next  = words_left_reg;
        pad_pending_next = pad_pending_reg;
        draw_kind_next   = draw_kind_reg;
        draw_pos_next    = draw_pos_reg;
        res0             = RESULT_NONE;
        res1             = RESULT_NONE;
        n_res            = 2'd0;

        unique case (phase_reg)
            PH_HDR0:
            begin
                header_word_next = cmd_word;
                phase_next       = PH_HDR1;
            end
            PH_HDR1:
            begin
                case (opcode) inside
                    OP_NOP0, OP_NOP3, OP_NOP9:
                    begin
                        phase_next = PH_HDR0;
                    end
                    OP_LOAD_STATE:
                    begin
                        n_res = 2'd1;
                        if (count_field == '0)
                        begin
                            res0.kind  = KIND_ERROR;
                            res0.value = header_word_reg;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            res0.kind               = KIND_WRITE;
                            res0.reg_index          = {1'b0, addr_field};
                            res0.value              = cmd_word;
                            res0.clear_vertex_first = (addr_field == vertex_block_index_reg);
                            next_index_next  = {1'b0, addr_field} + 17'd1;
                            words_left_next  = load_left;
                            pad_pending_next = load_left[0];
                            phase_next       = (load_left != '0) ? PH_LOAD : PH_HDR0;
                        end
                    end
                    OP_FILL_STATE:
                    begin
                        n_res      = 2'd1;
                        res0.kind  = KIND_FILL;
                        phase_next = PH_HDR0;
                    end
                    OP_DRAW_IDX, OP_DRAW_6:
                    begin
                        n_res           = 2'd2;
                        res0.kind       = KIND_DRAW;
                        res0.value      = header_word_reg;
                        res1.kind       = KIND_DRAW;
                        res1.value      = cmd_word;
                        res1.draw_slot  = 3'd1;
                        draw_kind_next  = (opcode == OP_DRAW_6);
                        draw_pos_next   = 3'd2;
                        phase_next      = PH_DRAW;
                    end
                    default:
                    begin
                        n_res      = 2'd1;
                        res0.kind  = KIND_ERROR;
                        res0.value = header_word_reg;
                        phase_next = PH_HALT;
                    end
                endcase
            end
            PH_LOAD:
            begin
                n_res           = 2'd1;
                res0.kind       = KIND_WRITE;
                res0.reg_index  = next_index_reg;
                res0.value      = cmd_word;
                next_index_next = next_index_reg + 17'd1;
                words_left_next = words_dec;
                if (words_dec == '0)
                begin
                    phase_next = pad_pending_reg ? PH_PAD : PH_HDR0;
                end
            end
            PH_PAD:
            begin
                pad_pending_next = 1'b0;
                phase_next       = PH_HDR0;
            end
            PH_DRAW:
            begin
                n_res          = 2'd1;
                res0.kind      = KIND_DRAW;
                res0.value     = cmd_word;
                res0.draw_slot = draw_pos_reg;
                res0.draw_end  = draw_done;
                if (draw_done)
                begin
                    // The short record is followed by clearing index-stream control.
                    if (!draw_kind_reg)
                    begin
                        n_res          = 2'd2;
                        res1.kind      = KIND_WRITE;
                        res1.reg_index = {1'b0, index_control_index_reg};
                    end
                    draw_pos_next = 3'd0;
                    phase_next    = PH_HDR0;
                end
                else
                begin
                    draw_pos_next = draw_pos_reg + 3'd1;
                end
            end
            default: ;
        endcase

        res0.last_of_item = (n_res == 2'd1);
        res1.last_of_item = 1'b1;
    end

    assign push_n = in_accept ? n_res : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR0;
            header_word_reg <= '0;
            next_index_reg  <= '0;
            words_left_reg  <= '0;
            pad_pending_reg <= 1'b0;
            draw_kind_reg   <= 1'b0;
            draw_pos_reg    <= '0;
            rd_ptr_reg      <= 1'b0;
            wr_ptr_reg      <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg       <= phase_next;
                header_word_reg <= header_word_next;
                next_index_reg  <= next_index_next;
                words_left_reg  <= words_left_next;
                pad_pending_reg <= pad_pending_next;
                draw_kind_reg   <= draw_kind_next;
                draw_pos_reg    <= draw_pos_next;
            end
            rd_ptr_reg <= rd_ptr_reg ^ out_pop;
            wr_ptr_reg <= wr_ptr_reg ^ push_n[0];
            count_reg  <= count_reg - {1'b0, out_pop} + push_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[~wr_ptr_reg] <= res1;
        end
    end

    assign kind               = queue_reg[rd_ptr_reg].kind;
    assign reg_index          = queue_reg[rd_ptr_reg].reg_index;
    assign value              = queue_reg[rd_ptr_reg].value;
    assign clear_vertex_first = queue_reg[rd_ptr_reg].clear_vertex_first;
    assign draw_slot          = queue_reg[rd_ptr_reg].draw_slot;
    assign draw_end           = queue_reg[rd_ptr_reg].draw_end;
    assign last_of_item       = queue_reg[rd_ptr_reg].last_of_item;

endmodule

// ----- rtl/gcsp_checker.sv -----
// ----------------------------------------------------------------------------
// gcsp_checker
// Port-level checks on the result channel of the command stream parser.
// ----------------------------------------------------------------------------
module gcsp_checker
    import gcsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [WORD_W-1:0]  value,
    input  logic               clear_vertex_first,
    input  logic [SLOT_W-1:0]  draw_slot,
    input  logic               draw_end,
    input  logic               last_of_item
);

    // A stalled result stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value))
        else $error("stalled result changed");

    // An error is always the only result of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ERROR) |-> last_of_item)
        else $error("error result not last of item");

    // A draw record ends only on its fourth or sixth word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && draw_end |->
            (kind == KIND_DRAW) && ((draw_slot == DRAW_LAST_SHORT) ||
                                    (draw_slot == DRAW_LAST_LONG)))
        else $error("draw end on wrong slot");

    // The vertex clear flag only rides on a state write.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clear_vertex_first |-> (kind == KIND_WRITE))
        else $error("clear flag on non-write result");

endmodule

bind gpu_command_stream_parser gcsp_checker u_gcsp_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .kind               (kind),
    .value              (value),
    .clear_vertex_first (clear_vertex_first),
    .draw_slot          (draw_slot),
    .draw_end           (draw_end),
    .last_of_item       (last_of_item)
);

// ----- dv/gcsp_stream_checker.sv -----
// ----------------------------------------------------------------------------
// gcsp_stream_checker
// Watches the command word input, the result output and the register port of
// the GPU command stream parser. It decodes every accepted command word into
// the results the parser owes, then compares each accepted result against
// the oldest one still due.
// ----------------------------------------------------------------------------
module gcsp_stream_checker
    import gcsp_pkg::*;
#(
    parameter logic [2:0]         VERTEX_REG_ADDR  = 3'd0,
    parameter logic [2:0]         CONTROL_REG_ADDR = 3'd4,
    parameter logic [INDEX_W-1:0] VERTEX_RESET     = 16'd384
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [WORD_W-1:0] cmd_word,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [KIND_W-1:0] kind,
    input  logic [REG_W-1:0]  reg_index,
    input  logic [WORD_W-1:0] value,
    input  logic              clear_vertex_first,
    input  logic [SLOT_W-1:0] draw_slot,
    input  logic              draw_end,
    input  logic              last_of_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                mismatch_count,
    output int                results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PH_FIRST_HEADER,
        PH_SECOND_HEADER,
        PH_LOAD_DATA,
        PH_PAD_WORD,
        PH_DRAW_WORDS,
        PH_HALTED
    } parse_phase_t;

    parse_phase_t        parse_phase;
    logic [WORD_W-1:0]   header;
    logic [REG_W-1:0]    load_index;
    logic [WORDS_W-1:0]  load_left;
    logic                load_pad;
    logic                draw_long;
    logic [SLOT_W-1:0]   draw_pos;
    logic [INDEX_W-1:0]  vertex_block_index;
    logic [INDEX_W-1:0]  index_control_index;
    result_t             due_results[$];
    int                  errors_seen;

    function automatic result_t make_result(
        input logic [KIND_W-1:0] code,
        input logic [REG_W-1:0]  index,
        input logic [WORD_W-1:0] data,
        input logic              clear,
        input logic [SLOT_W-1:0] slot,
        input logic              closing
    );
        result_t r;
        r = RESULT_NONE;
        r.kind               = code;
        r.reg_index          = index;
        r.value              = data;
        r.clear_vertex_first = clear;
        r.draw_slot          = slot;
        r.draw_end           = closing;
        return r;
    endfunction

    // Advances the parse state by one command word and queues what it owes.
    function automatic void decode_command_word(input logic [WORD_W-1:0] word);
        logic [OP_W-1:0]    op;
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] start;
        logic [SLOT_W-1:0]  last_slot;
        int                 produced;
        produced = 0;
        case (parse_phase)
            PH_FIRST_HEADER:
            begin
                header      = word;
                parse_phase = PH_SECOND_HEADER;
            end
            PH_SECOND_HEADER:
            begin
                op    = header[WORD_W-1 -: OP_W];
                count = header[16 +: COUNT_W];
                start = header[INDEX_W-1:0];
                case (op) inside
                    OP_NOP0, OP_NOP3, OP_NOP9:
                        parse_phase = PH_FIRST_HEADER;
                    OP_LOAD_STATE:
                    begin
                        if (count == '0)
                        begin
                            due_results.push_back(make_result(KIND_ERROR, '0, header,
                                                              1'b0, '0, 1'b0));
                            produced++;
                            parse_phase = PH_HALTED;
                        end
                        else
                        begin
                            due_results.push_back(make_result(KIND_WRITE, REG_W'(start), word,
                                start == vertex_block_index, '0, 1'b0));
                            produced++;
                            load_index  = REG_W'(start) + 1'b1;
                            load_left   = WORDS_W'(count) - 1'b1;
                            load_pad    = load_left[0];
                            parse_phase = (load_left != '0) ? PH_LOAD_DATA : PH_FIRST_HEADER;
                        end
                    end
                    OP_FILL_STATE:
                    begin
                        due_results.push_back(make_result(KIND_FILL, '0, '0, 1'b0, '0, 1'b0));
                        produced++;
                        parse_phase = PH_FIRST_HEADER;
                    end
                    OP_DRAW_IDX, OP_DRAW_6:
                    begin
                        due_results.push_back(make_result(KIND_DRAW, '0, header,
                                                          1'b0, SLOT_W'(0), 1'b0));
                        due_results.push_back(make_result(KIND_DRAW, '0, word,
                                                          1'b0, SLOT_W'(1), 1'b0));
                        produced += 2;
                        draw_long   = (op == OP_DRAW_6);
                        draw_pos    = SLOT_W'(2);
                        parse_phase = PH_DRAW_WORDS;
                    end
                    default:
                    begin
                        due_results.push_back(make_result(KIND_ERROR, '0, header,
                                                          1'b0, '0, 1'b0));
                        produced++;
                        parse_phase = PH_HALTED;
                    end
                endcase
            end
            PH_LOAD_DATA:
            begin
                due_results.push_back(make_result(KIND_WRITE, load_index, word,
                                                  1'b0, '0, 1'b0));
                produced++;
                load_index = load_index + 1'b1;
                load_left  = load_left - 1'b1;
                if (load_left == '0)
                    parse_phase = load_pad ? PH_PAD_WORD : PH_FIRST_HEADER;
            end
            PH_PAD_WORD:
            begin
                load_pad    = 1'b0;
                parse_phase = PH_FIRST_HEADER;
            end
            PH_DRAW_WORDS:
            begin
                last_slot = draw_long ? DRAW_LAST_LONG : DRAW_LAST_SHORT;
                due_results.push_back(make_result(KIND_DRAW, '0, word, 1'b0, draw_pos,
                                                  draw_pos >= last_slot));
                produced++;
                if (draw_pos >= last_slot)
                begin
                    // A four-word record is followed by clearing the index stream control.
                    if (!draw_long)
                    begin
                        due_results.push_back(make_result(KIND_WRITE,
                            REG_W'(index_control_index), '0, 1'b0, '0, 1'b0));
                        produced++;
                    end
                    draw_pos    = '0;
                    parse_phase = PH_FIRST_HEADER;
                end
                else
                begin
                    draw_pos = draw_pos + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (produced > 0)
            due_results[due_results.size() - 1].last_of_item = 1'b1;
    endfunction

    function automatic void check_field(
        input string             name,
        input logic [WORD_W-1:0] expected,
        input logic [WORD_W-1:0] actual
    );
        if (expected !== actual)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
            errors_seen++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            parse_phase         = PH_FIRST_HEADER;
            header              = '0;
            load_index          = '0;
            load_left           = '0;
            load_pad            = 1'b0;
            draw_long           = 1'b0;
            draw_pos            = '0;
            vertex_block_index  = VERTEX_RESET;
            index_control_index = '0;
            due_results.delete();
            results_due <= 0;
        end
        else
        begin
            // Results leave before the word accepted at this edge is decoded.
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with nothing due: kind %0d, value 0x%0h", kind, value);
                    errors_seen++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("reg_index", want.reg_index, reg_index);
                    check_field("value", want.value, value);
                    check_field("clear_vertex_first", want.clear_vertex_first,
                                clear_vertex_first);
                    check_field("draw_slot", want.draw_slot, draw_slot);
                    check_field("draw_end", want.draw_end, draw_end);
                    check_field("last_of_item", want.last_of_item, last_of_item);
                end
            end
            if (in_valid && !in_stall)
                decode_command_word(cmd_word);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == VERTEX_REG_ADDR)
                    vertex_block_index = pwdata[INDEX_W-1:0];
                else if (paddr == CONTROL_REG_ADDR)
                    index_control_index = pwdata[INDEX_W-1:0];
            end
            results_due <= due_results.size();
        end
        mismatch_count <= errors_seen;
    end

endmodule

// ----- dv/gpu_command_stream_parser_tb.sv -----
// ----------------------------------------------------------------------------
// gpu_command_stream_parser_tb
// Drives command streams into the parser: a short directed pass over every
// opcode and corner case, then random well-formed commands under several
// register settings, and finally an error that halts the parser. Both sides
// idle at random but in one steady burst; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module gpu_command_stream_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gcsp_pkg::*;

    localparam logic [2:0]         ADDR_VERTEX_BLOCK  = 3'd0;
    localparam logic [2:0]         ADDR_INDEX_CONTROL = 3'd4;
    localparam logic [INDEX_W-1:0] VERTEX_RESET       = 16'd384;
    localparam int                 REST_CYCLES        = 4;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [WORD_W-1:0]  cmd_word  = '0;
    logic               out_stall = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [2:0]         paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic               steady    = 1'b0;

    logic               in_stall;
    logic               out_valid;
    logic [KIND_W-1:0]  kind;
    logic [REG_W-1:0]   reg_index;
    logic [WORD_W-1:0]  value;
    logic               clear_vertex_first;
    logic [SLOT_W-1:0]  draw_slot;
    logic               draw_end;
    logic               last_of_item;
    logic [31:0]        prdata;
    logic               pready;
    int                 mismatch_count;
    int                 results_due;

    int                 words_sent   = 0;
    logic [INDEX_W-1:0] vertex_target = VERTEX_RESET;

    gpu_command_stream_parser u_dut (.*);

    gcsp_stream_checker #(
        .VERTEX_REG_ADDR  (ADDR_VERTEX_BLOCK),
        .CONTROL_REG_ADDR (ADDR_INDEX_CONTROL),
        .VERTEX_RESET     (VERTEX_RESET)
    ) u_checker (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
        out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 27);

    function automatic logic [WORD_W-1:0] pick_data_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] word);
        while (!steady && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd_word <= word;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] start, input logic [COUNT_W-1:0] count);
        logic spare;
        spare = 1'($urandom_range(0, 1));
        send_word({OP_LOAD_STATE, spare, count, start});
        for (int i = 0; i < count; i++)
            send_word(pick_data_word());
        // An even count leaves an odd payload after the first value, so a pad word follows.
        if (count[0] == 1'b0)
            send_word(pick_data_word());
    endtask

    task automatic send_draw(input logic [OP_W-1:0] op);
        logic [WORD_W-1:0] header;
        int                tail;
        header = $urandom();
        header[WORD_W-1 -: OP_W] = op;
        tail = (op == OP_DRAW_6) ? DRAW_LAST_LONG - 1 : DRAW_LAST_SHORT - 1;
        send_word(header);
        send_word(pick_data_word());
        repeat (tail) send_word(pick_data_word());
    endtask

    task automatic send_pair(input logic [OP_W-1:0] op);
        logic [WORD_W-1:0] header;
        header = $urandom();
        header[WORD_W-1 -: OP_W] = op;
        send_word(header);
        send_word(pick_data_word());
    endtask

    task automatic run_burst(input int items);
        int                 stop;
        int                 roll;
        logic [INDEX_W-1:0] start;
        logic [COUNT_W-1:0] count;
        stop = words_sent + items;
        while (words_sent < stop)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                case ($urandom_range(0, 7))
                    0, 1:    start = vertex_target;
                    2:       start = INDEX_W'($urandom_range(16'hfff0, 16'hffff));
                    default: start = INDEX_W'($urandom_range(0, 16'hffff));
                endcase
                count = ($urandom_range(0, 15) == 0) ? COUNT_W'($urandom_range(1, 64))
                                                     : COUNT_W'($urandom_range(1, 8));
                send_load(start, count);
            end
            else if (roll < 60)
                send_draw(OP_DRAW_IDX);
            else if (roll < 75)
                send_draw(OP_DRAW_6);
            else if (roll < 85)
                send_pair(OP_FILL_STATE);
            else
            begin
                case ($urandom_range(0, 2))
                    0:       send_pair(OP_NOP0);
                    1:       send_pair(OP_NOP3);
                    default: send_pair(OP_NOP9);
                endcase
            end
        end
    endtask

    // Waits until every owed result has come, then rests for words
    // that owe nothing but may still be in flight.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
        repeat (REST_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [INDEX_W-1:0] setting);
        logic [31:0] word;
        word = $urandom();
        word[INDEX_W-1:0] = setting;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_VERTEX_BLOCK)
            vertex_target = setting;
    endtask

    initial
    begin
        logic [WORD_W-1:0] bad_header;
        logic [OP_W-1:0]   bad_op;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass with the registers at their reset values.
        send_word('0);
        send_word('0);
        send_word({OP_LOAD_STATE, 1'b1, 10'd1, VERTEX_RESET});
        send_word('1);
        send_load(16'hffff, 10'd2);
        send_pair(OP_FILL_STATE);
        send_draw(OP_DRAW_IDX);
        send_draw(OP_DRAW_6);
        send_pair(OP_NOP3);
        send_pair(OP_NOP9);
        drain();

        write_reg(ADDR_VERTEX_BLOCK, '0);
        write_reg(ADDR_INDEX_CONTROL, 16'hffff);
        steady <= 1'b1;
        run_burst(80);
        steady <= 1'b0;
        run_burst(40);
        drain();

        write_reg(ADDR_VERTEX_BLOCK, 16'hffff);
        write_reg(ADDR_INDEX_CONTROL, '0);
        // A long load, starting at the top index so the writes run past 16 bits.
        send_load(16'hffff, 10'h101);
        run_burst(100);
        drain();

        write_reg(ADDR_VERTEX_BLOCK, INDEX_W'($urandom_range(0, 16'hffff)));
        write_reg(ADDR_INDEX_CONTROL, INDEX_W'($urandom_range(0, 16'hffff)));
        run_burst(100);

        // An error halts the parser for good, so it comes last: either a load
        // with a zero count or an opcode the parser does not know.
        if ($urandom_range(0, 1) == 1)
        begin
            bad_header = $urandom();
            bad_header[WORD_W-1 -: OP_W] = OP_LOAD_STATE;
            bad_header[16 +: COUNT_W]    = '0;
        end
        else
        begin
            do bad_op = OP_W'($urandom_range(0, 31));
            while (bad_op inside {OP_NOP0, OP_LOAD_STATE, OP_FILL_STATE, OP_NOP3,
                                  OP_DRAW_IDX, OP_DRAW_6, OP_NOP9});
            bad_header = $urandom();
            bad_header[WORD_W-1 -: OP_W] = bad_op;
        end
        send_word(bad_header);
        send_word(pick_data_word());
        // Everything after the error must be swallowed without a result.
        send_draw(OP_DRAW_IDX);
        send_pair(OP_FILL_STATE);
        drain();

        if (mismatch_count == 0 && results_due == 0)
            $display("gpu_command_stream_parser_tb OK");
        else
            $display("gpu_command_stream_parser_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("gpu_command_stream_parser_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/gcsp_pkg.sv
rtl/gpu_command_stream_parser.sv
rtl/gcsp_checker.sv
dv/gcsp_stream_checker.sv
dv/gpu_command_stream_parser_tb.sv
